// File: design/afr_pkg.sv
package afr_pkg;

  // Frame pool size and page id width used for the default build.
  localparam int POOL_SIZE_DEF  = 16;
  localparam int PAGE_W         = 31;
  localparam int CAP_W          = 5;
  localparam int CAP_RESET      = 16;

  typedef enum logic [1:0] {
    REQ_ACCESS = 2'd0,
    REQ_SETEV  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EVICT  = 2'd3
  } req_op_t;

  typedef enum logic [1:0] {
    TAG_ABSENT   = 2'd0,
    TAG_RECENT   = 2'd1,
    TAG_FREQUENT = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_ABSENT  = 2'd1,
    ERR_PINNED  = 2'd2
  } err_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_OFIND,
    S_OPUSH,
    S_GFIND,
    S_DIV,
    S_ADAPT,
    S_TRIM,
    S_VSCAN,
    S_VDROP,
    S_DUP,
    S_GPUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [3:0]        frame_index;
    logic [PAGE_W-1:0] page_number;
    logic              evictable_flag;
  } req_t;

  typedef struct packed {
    logic       evicted_valid;
    logic [3:0] evicted_frame;
    logic [4:0] evictable_count;
    logic [1:0] error_code;
  } res_t;

  // Operation on one ordered list for the current cycle.
  typedef struct packed {
    logic push;
    logic drop;
    logic trim;
  } list_ctl_t;

endpackage

// File: design/arc_frame_replacer.sv
// ARC victim selector over a pool of frames. Assert start with a request
// while busy is low; busy then stays high until the single result has been
// shown for one cycle with out_valid high, and the result must be taken in
// that cycle since it is not held. One list entry is examined per cycle
// by a shared scan counter (an evict walks the frame lists and then both
// ghost lists), and a ghost hit can run a repeated-subtract divider. The
// capacity register may be written at any cycle the block is idle and is
// always ready.
module arc_frame_replacer #(
  parameter int POOL_SIZE = afr_pkg::POOL_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  afr_pkg::req_t            in_req,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [afr_pkg::CAP_W-1:0] cfg_data,
  output logic                     out_valid,
  output afr_pkg::res_t            out_res
);
  import afr_pkg::*;

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE+1);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [CAP_W-1:0]  cap_r;
  tag_t              tag_r [POOL_SIZE];
  tag_t              tag_nxt [POOL_SIZE];
  logic [POOL_SIZE-1:0] ev_r, ev_nxt;
  logic [PAGE_W-1:0] page_r [POOL_SIZE];
  logic              page_we;
  logic [LW-1:0]     tgt_r, tgt_nxt;
  logic [LW-1:0]     tot_r, tot_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [IW-1:0]     cf_r, cf_nxt;
  logic              lsel_r, lsel_nxt;
  logic              gsel_r, gsel_nxt;
  logic              second_r, second_nxt;
  logic [LW-1:0]     rem_r, rem_nxt;
  logic [LW-1:0]     q_r, q_nxt;
  logic              rv_r, rv_nxt;
  logic [IW-1:0]     rf_r, rf_nxt;
  err_code_t         err_r, err_nxt;
  logic [PAGE_W-1:0] cf_page_r;

  list_ctl_t         rec_ctl, frq_ctl, rgh_ctl, fgh_ctl;
  logic [IW-1:0]     drop_pos, scan_idx;
  logic [IW-1:0]     rec_rd, frq_rd;
  logic [PAGE_W-1:0] rgh_rd, fgh_rd;
  logic [LW-1:0]     rec_len, frq_len, rgh_len, fgh_len;

  logic [LW-1:0]     cap_eff;
  logic              in_range;
  logic [IW-1:0]     fin;
  logic              live;
  logic [IW-1:0]     ord_ent;
  logic [LW-1:0]     ord_len;
  logic [PAGE_W-1:0] gh_ent;
  logic [LW-1:0]     gh_len;
  logic [LW-1:0]     div_den;
  logic [LW:0]       tgt_sum;
  logic [LW:0]       rsum;
  logic [LW+1:0]     all_sum;

  // Effective capacity: zero acts as one, large values clamp to the pool.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = LW'(1);
    end else if (32'(cap_r) > POOL_SIZE) begin
      cap_eff = LW'(POOL_SIZE);
    end else begin
      cap_eff = LW'(cap_r);
    end
  end

  // The frame of the request held since its transfer.
  assign in_range = 32'(req_r.frame_index) < POOL_SIZE;
  assign fin      = IW'(req_r.frame_index);
  assign live     = in_range && (tag_r[fin] != TAG_ABSENT);

  // Shared scan read port selection.
  assign scan_idx = (state_r == S_VSCAN) ? IW'(cnt_r - LW'(1)) : IW'(cnt_r);
  assign ord_ent  = lsel_r ? frq_rd : rec_rd;
  assign ord_len  = lsel_r ? frq_len : rec_len;
  assign gh_ent   = gsel_r ? fgh_rd : rgh_rd;
  assign gh_len   = gsel_r ? fgh_len : rgh_len;
  assign div_den  = gsel_r ? fgh_len : rgh_len;
  assign tgt_sum  = {1'b0, tgt_r} + {1'b0, q_r};
  assign rsum     = {1'b0, rec_len} + {1'b0, rgh_len};
  assign all_sum  = {1'b0, rsum} + {2'b0, frq_len} + {2'b0, fgh_len};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DISP;
      S_DISP: begin
        unique case (req_op_t'(req_r.req_type))
          REQ_ACCESS: begin
            if (!in_range) state_nxt = S_DONE;
            else if (tag_r[fin] != TAG_ABSENT) state_nxt = S_OFIND;
            else state_nxt = S_GFIND;
          end
          REQ_SETEV:  state_nxt = S_DONE;
          REQ_REMOVE: state_nxt = (live && ev_r[fin]) ? S_OFIND : S_DONE;
          REQ_EVICT:  state_nxt = (tot_r == '0) ? S_DONE : S_VSCAN;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_OFIND: begin
        if (cnt_r == ord_len || ord_ent == cf_r) begin
          state_nxt = (req_op_t'(req_r.req_type) == REQ_ACCESS) ? S_OPUSH : S_DONE;
        end
      end
      S_OPUSH: state_nxt = S_DONE;
      S_GFIND: begin
        if (cnt_r == gh_len) begin
          if (gsel_r) state_nxt = S_TRIM;
        end else if (gh_ent == req_r.page_number) begin
          if (!gsel_r) state_nxt = (rgh_len >= fgh_len) ? S_ADAPT : S_DIV;
          else state_nxt = (fgh_len >= rgh_len) ? S_ADAPT : S_DIV;
        end
      end
      S_DIV:   if (rem_r < div_den) state_nxt = S_ADAPT;
      S_ADAPT: state_nxt = S_DONE;
      S_TRIM:  state_nxt = S_DONE;
      S_VSCAN: begin
        if (cnt_r == '0) begin
          if (second_r) state_nxt = S_DONE;
        end else if (ev_r[ord_ent]) begin
          state_nxt = S_VDROP;
        end
      end
      S_VDROP: state_nxt = S_DUP;
      S_DUP: begin
        if (gsel_r && (cnt_r == gh_len || gh_ent == cf_page_r)) state_nxt = S_GPUSH;
      end
      S_GPUSH: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and list controls.
  always_comb begin
    req_nxt    = req_r;
    tag_nxt    = tag_r;
    ev_nxt     = ev_r;
    page_we    = 1'b0;
    tgt_nxt    = tgt_r;
    tot_nxt    = tot_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    cf_nxt     = cf_r;
    lsel_nxt   = lsel_r;
    gsel_nxt   = gsel_r;
    second_nxt = second_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    rv_nxt     = rv_r;
    rf_nxt     = rf_r;
    err_nxt    = err_r;
    rec_ctl    = '0;
    frq_ctl    = '0;
    rgh_ctl    = '0;
    fgh_ctl    = '0;
    drop_pos   = pos_r;
    unique case (state_r)
      S_IDLE: if (start) req_nxt = in_req;
      S_DISP: begin
        rv_nxt  = 1'b0;
        rf_nxt  = '0;
        err_nxt = ERR_OK;
        cf_nxt  = fin;
        cnt_nxt = '0;
        gsel_nxt = 1'b0;
        second_nxt = 1'b0;
        lsel_nxt = in_range && (tag_r[fin] == TAG_FREQUENT);
        unique case (req_op_t'(req_r.req_type))
          REQ_ACCESS: ;
          REQ_SETEV: begin
            if (!live) begin
              err_nxt = ERR_ABSENT;
            end else if (ev_r[fin] && !req_r.evictable_flag) begin
              ev_nxt[fin] = 1'b0;
              if (tot_r != '0) tot_nxt = tot_r - LW'(1);
            end else if (!ev_r[fin] && req_r.evictable_flag) begin
              ev_nxt[fin] = 1'b1;
              tot_nxt = tot_r + LW'(1);
            end
          end
          REQ_REMOVE: if (live && !ev_r[fin]) err_nxt = ERR_PINNED;
          REQ_EVICT: begin
            lsel_nxt = !(rec_len >= tgt_r);
            cnt_nxt  = (rec_len >= tgt_r) ? rec_len : frq_len;
          end
          default: ;
        endcase
      end
      // Find the frame in its order list and close the gap.
      S_OFIND: begin
        drop_pos = IW'(cnt_r);
        if (cnt_r != ord_len) begin
          if (ord_ent == cf_r) begin
            if (lsel_r) frq_ctl.drop = 1'b1;
            else rec_ctl.drop = 1'b1;
            if (req_op_t'(req_r.req_type) == REQ_REMOVE) begin
              tag_nxt[cf_r] = TAG_ABSENT;
              ev_nxt[cf_r]  = 1'b0;
              if (tot_r != '0) tot_nxt = tot_r - LW'(1);
            end
          end else begin
            cnt_nxt = cnt_r + LW'(1);
          end
        end
      end
      S_OPUSH: begin
        frq_ctl.push  = 1'b1;
        tag_nxt[cf_r] = TAG_FREQUENT;
      end
      // Look for the page in the recent ghost list, then the frequent one.
      S_GFIND: begin
        if (cnt_r == gh_len) begin
          gsel_nxt = 1'b1;
          cnt_nxt  = '0;
        end else if (gh_ent == req_r.page_number) begin
          pos_nxt = IW'(cnt_r);
          q_nxt   = LW'(1);
          if (!gsel_r && rgh_len < fgh_len) begin
            q_nxt   = '0;
            rem_nxt = fgh_len;
          end else if (gsel_r && fgh_len < rgh_len) begin
            q_nxt   = '0;
            rem_nxt = rgh_len;
          end
        end else begin
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      // Quotient of the ghost sizes by repeated subtraction.
      S_DIV: begin
        if (rem_r >= div_den) begin
          rem_nxt = rem_r - div_den;
          q_nxt   = q_r + LW'(1);
        end
      end
      S_ADAPT: begin
        if (!gsel_r) begin
          tgt_nxt = (tgt_sum > {1'b0, cap_eff}) ? cap_eff : LW'(tgt_sum);
          rgh_ctl.drop = 1'b1;
        end else begin
          tgt_nxt = (tgt_r > q_r) ? (tgt_r - q_r) : '0;
          fgh_ctl.drop = 1'b1;
        end
        page_we       = 1'b1;
        ev_nxt[cf_r]  = 1'b0;
        tag_nxt[cf_r] = TAG_FREQUENT;
        frq_ctl.push  = 1'b1;
      end
      // Miss in both ghosts: trim a ghost list if needed and insert as recent.
      S_TRIM: begin
        if (rsum == {1'b0, cap_eff}) begin
          rgh_ctl.trim = 1'b1;
        end else if (rsum < {1'b0, cap_eff}) begin
          if (all_sum == {1'b0, cap_eff, 1'b0}) fgh_ctl.trim = 1'b1;
        end
        page_we       = 1'b1;
        ev_nxt[cf_r]  = 1'b0;
        tag_nxt[cf_r] = TAG_RECENT;
        rec_ctl.push  = 1'b1;
      end
      // Walk a frame list from its oldest entry for an evictable frame.
      S_VSCAN: begin
        if (cnt_r == '0) begin
          if (!second_r) begin
            second_nxt = 1'b1;
            lsel_nxt   = !lsel_r;
            cnt_nxt    = lsel_r ? rec_len : frq_len;
          end
        end else if (ev_r[ord_ent]) begin
          pos_nxt = IW'(cnt_r - LW'(1));
          cf_nxt  = ord_ent;
        end else begin
          cnt_nxt = cnt_r - LW'(1);
        end
      end
      S_VDROP: begin
        if (lsel_r) frq_ctl.drop = 1'b1;
        else rec_ctl.drop = 1'b1;
        tag_nxt[cf_r] = TAG_ABSENT;
        ev_nxt[cf_r]  = 1'b0;
        if (tot_r != '0) tot_nxt = tot_r - LW'(1);
        rv_nxt   = 1'b1;
        rf_nxt   = cf_r;
        gsel_nxt = 1'b0;
        cnt_nxt  = '0;
      end
      // Remove the victim's page from either ghost list before the push.
      S_DUP: begin
        drop_pos = IW'(cnt_r);
        if (cnt_r == gh_len || gh_ent == cf_page_r) begin
          if (cnt_r != gh_len) begin
            if (gsel_r) fgh_ctl.drop = 1'b1;
            else rgh_ctl.drop = 1'b1;
          end
          gsel_nxt = 1'b1;
          cnt_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      S_GPUSH: begin
        if (lsel_r) fgh_ctl.push = 1'b1;
        else rgh_ctl.push = 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= CAP_W'(CAP_RESET);
      ev_r    <= '0;
      tgt_r   <= '0;
      tot_r   <= '0;
      for (int i = 0; i < POOL_SIZE; i++) tag_r[i] <= TAG_ABSENT;
    end else begin
      state_r <= state_nxt;
      ev_r    <= ev_nxt;
      tgt_r   <= tgt_nxt;
      tot_r   <= tot_nxt;
      for (int i = 0; i < POOL_SIZE; i++) tag_r[i] <= tag_nxt[i];
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
    end
  end

  // Working registers and the page store; the page of the current frame
  // is registered together with the frame itself.
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    cnt_r     <= cnt_nxt;
    pos_r     <= pos_nxt;
    cf_r      <= cf_nxt;
    lsel_r    <= lsel_nxt;
    gsel_r    <= gsel_nxt;
    second_r  <= second_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    rv_r      <= rv_nxt;
    rf_r      <= rf_nxt;
    err_r     <= err_nxt;
    cf_page_r <= page_r[cf_nxt];
    if (page_we) page_r[cf_r] <= req_r.page_number;
  end

  afr_list #(.N(POOL_SIZE), .W(IW)) u_rec (
    .clk(clk), .rst_n(rst_n), .ctl(rec_ctl), .pos(drop_pos), .push_data(cf_r),
    .rd_idx(scan_idx), .rd_data(rec_rd), .len(rec_len)
  );

  afr_list #(.N(POOL_SIZE), .W(IW)) u_frq (
    .clk(clk), .rst_n(rst_n), .ctl(frq_ctl), .pos(drop_pos), .push_data(cf_r),
    .rd_idx(scan_idx), .rd_data(frq_rd), .len(frq_len)
  );

  afr_list #(.N(POOL_SIZE), .W(PAGE_W)) u_rgh (
    .clk(clk), .rst_n(rst_n), .ctl(rgh_ctl), .pos(drop_pos), .push_data(cf_page_r),
    .rd_idx(scan_idx), .rd_data(rgh_rd), .len(rgh_len)
  );

  afr_list #(.N(POOL_SIZE), .W(PAGE_W)) u_fgh (
    .clk(clk), .rst_n(rst_n), .ctl(fgh_ctl), .pos(drop_pos), .push_data(cf_page_r),
    .rd_idx(scan_idx), .rd_data(fgh_rd), .len(fgh_len)
  );

  // Result transfer.
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_DONE);
  assign out_res.evicted_valid   = rv_r;
  assign out_res.evicted_frame   = 4'(rf_r);
  assign out_res.evictable_count = 5'(tot_r);
  assign out_res.error_code      = err_r;

  // A result always ends a request and frees the block next cycle.
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("block still busy after result");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");

  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tot_r) <= POOL_SIZE) else $error("evictable count overflow");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rec_len) + 32'(frq_len) <= POOL_SIZE) else $error("too many live frames");

endmodule

// File: design/afr_list.sv
module afr_list #(
  parameter int N = afr_pkg::POOL_SIZE_DEF,
  parameter int W = afr_pkg::PAGE_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  afr_pkg::list_ctl_t     ctl,
  input  logic [$clog2(N)-1:0]   pos,
  input  logic [W-1:0]           push_data,
  input  logic [$clog2(N)-1:0]   rd_idx,
  output logic [W-1:0]           rd_data,
  output logic [$clog2(N+1)-1:0] len
);
  import afr_pkg::*;

  localparam int IW = $clog2(N);
  localparam int LW = $clog2(N+1);

  logic [W-1:0]  ent_r   [N];
  logic [W-1:0]  ent_nxt [N];
  logic [LW-1:0] len_r, len_nxt;

  // Push shifts every entry one place older; drop closes the gap at pos.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ent_nxt[i] = ent_r[i];
      if (ctl.push) begin
        ent_nxt[i] = (i == 0) ? push_data : ent_r[(i == 0) ? 0 : i-1];
      end else if (ctl.drop && (IW'(i) >= pos) && (i < N-1)) begin
        ent_nxt[i] = ent_r[(i < N-1) ? i+1 : i];
      end
    end
  end

  // Length update; a push onto a full list loses its oldest entry.
  always_comb begin
    len_nxt = len_r;
    if (ctl.push) begin
      if (len_r != LW'(N)) len_nxt = len_r + LW'(1);
    end else if (ctl.drop) begin
      if (LW'(pos) < len_r) len_nxt = len_r - LW'(1);
    end else if (ctl.trim) begin
      if (len_r != '0) len_nxt = len_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) ent_r[i] <= ent_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign rd_data = ent_r[rd_idx];
  assign len     = len_r;

endmodule

// File: tb/tb_arc_frame_replacer.sv
`timescale 1ns / 100ps

module tb_arc_frame_replacer;
  import afr_pkg::*;

  localparam int NF = 16;

  // Golden state of the ARC policy, kept beside the block.
  class arc_scoreboard;
    int unsigned recent_q[$];
    int unsigned freq_q[$];
    logic [PAGE_W-1:0] rghost_q[$];
    logic [PAGE_W-1:0] fghost_q[$];
    tag_t tag[NF];
    bit ev[NF];
    logic [PAGE_W-1:0] page_of[NF];
    int unsigned target;
    int unsigned ev_total;
    int unsigned capacity;
    res_t pending_q[$];
    int errors;

    function void clear();
      recent_q.delete();
      freq_q.delete();
      rghost_q.delete();
      fghost_q.delete();
      for (int i = 0; i < NF; i++) begin
        tag[i] = TAG_ABSENT;
        ev[i] = 0;
        page_of[i] = '0;
      end
      target = 0;
      ev_total = 0;
      capacity = CAP_RESET;
      pending_q.delete();
      errors = 0;
    endfunction

    function int unsigned eff_cap();
      if (capacity == 0) return 1;
      if (capacity > NF) return NF;
      return capacity;
    endfunction

    function int find_frame(ref int unsigned q[$], input int unsigned f);
      for (int i = 0; i < q.size(); i++) if (q[i] == f) return i;
      return -1;
    endfunction

    function int find_page(ref logic [PAGE_W-1:0] q[$], input logic [PAGE_W-1:0] p);
      for (int i = 0; i < q.size(); i++) if (q[i] == p) return i;
      return -1;
    endfunction

    function void ghost_insert(bit to_freq, logic [PAGE_W-1:0] p);
      int pos;
      pos = find_page(rghost_q, p);
      if (pos >= 0) rghost_q.delete(pos);
      pos = find_page(fghost_q, p);
      if (pos >= 0) fghost_q.delete(pos);
      if (to_freq) begin
        if (fghost_q.size() >= NF) fghost_q.delete(fghost_q.size() - 1);
        fghost_q.insert(0, p);
      end else begin
        if (rghost_q.size() >= NF) rghost_q.delete(rghost_q.size() - 1);
        rghost_q.insert(0, p);
      end
    endfunction

    // Oldest evictable frame of one list; -1 when there is none.
    function int take_victim(bit from_freq);
      int unsigned f;
      for (int i = (from_freq ? freq_q.size() : recent_q.size()) - 1; i >= 0; i--) begin
        f = from_freq ? freq_q[i] : recent_q[i];
        if (ev[f]) begin
          if (from_freq) freq_q.delete(i);
          else recent_q.delete(i);
          tag[f] = TAG_ABSENT;
          ev[f] = 0;
          if (ev_total > 0) ev_total--;
          ghost_insert(from_freq, page_of[f]);
          return f;
        end
      end
      return -1;
    endfunction

    function void access(int unsigned f, logic [PAGE_W-1:0] p);
      int unsigned cap, b1, b2, delta, rl;
      int pos;
      bit hit;
      cap = eff_cap();
      if (tag[f] != TAG_ABSENT) begin
        if (tag[f] == TAG_RECENT) recent_q.delete(find_frame(recent_q, f));
        else freq_q.delete(find_frame(freq_q, f));
        tag[f] = TAG_FREQUENT;
        freq_q.insert(0, f);
        return;
      end
      b1 = rghost_q.size();
      b2 = fghost_q.size();
      hit = 1;
      pos = find_page(rghost_q, p);
      if (pos >= 0) begin
        delta = (b1 >= b2) ? 1 : b2 / b1;
        target = target + delta;
        if (target > cap) target = cap;
        rghost_q.delete(pos);
      end else begin
        pos = find_page(fghost_q, p);
        if (pos >= 0) begin
          delta = (b2 >= b1) ? 1 : b1 / b2;
          target = (target > delta) ? target - delta : 0;
          fghost_q.delete(pos);
        end else hit = 0;
      end
      page_of[f] = p;
      ev[f] = 0;
      if (hit) begin
        tag[f] = TAG_FREQUENT;
        freq_q.insert(0, f);
        return;
      end
      rl = recent_q.size() + rghost_q.size();
      if (rl == cap) begin
        if (rghost_q.size() > 0) rghost_q.delete(rghost_q.size() - 1);
      end else if (rl < cap) begin
        if (rl + freq_q.size() + fghost_q.size() == 2 * cap && fghost_q.size() > 0)
          fghost_q.delete(fghost_q.size() - 1);
      end
      tag[f] = TAG_RECENT;
      recent_q.insert(0, f);
    endfunction

    // Notes one accepted request and queues the result it must give.
    function void note_request(req_t r);
      res_t e;
      int unsigned f;
      int v;
      bit live;
      f = 32'(r.frame_index);
      live = tag[f] != TAG_ABSENT;
      e = '0;
      e.error_code = ERR_OK;
      case (req_op_t'(r.req_type))
        REQ_ACCESS: begin
          access(f, r.page_number);
        end
        REQ_SETEV: begin
          if (!live) e.error_code = ERR_ABSENT;
          else if (ev[f] && !r.evictable_flag) begin
            ev[f] = 0;
            if (ev_total > 0) ev_total--;
          end else if (!ev[f] && r.evictable_flag) begin
            ev[f] = 1;
            ev_total++;
          end
        end
        REQ_REMOVE: begin
          if (live) begin
            if (!ev[f]) e.error_code = ERR_PINNED;
            else begin
              if (tag[f] == TAG_FREQUENT) freq_q.delete(find_frame(freq_q, f));
              else recent_q.delete(find_frame(recent_q, f));
              tag[f] = TAG_ABSENT;
              ev[f] = 0;
              if (ev_total > 0) ev_total--;
            end
          end
        end
        default: begin
          if (ev_total > 0) begin
            v = take_victim(!(recent_q.size() >= target));
            if (v < 0) v = take_victim(recent_q.size() >= target);
            if (v >= 0) begin
              e.evicted_valid = 1;
              e.evicted_frame = 4'(v);
            end
          end
        end
      endcase
      e.evictable_count = 5'(ev_total);
      pending_q.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.evicted_valid !== e.evicted_valid) begin
        $error("evicted_valid: expected %0d, got %0d", e.evicted_valid, got.evicted_valid);
        errors++;
      end
      if (got.evicted_frame !== e.evicted_frame) begin
        $error("evicted_frame: expected %0d, got %0d", e.evicted_frame, got.evicted_frame);
        errors++;
      end
      if (got.evictable_count !== e.evictable_count) begin
        $error("evictable_count: expected %0d, got %0d", e.evictable_count,
               got.evictable_count);
        errors++;
      end
      if (got.error_code !== e.error_code) begin
        $error("error_code: expected %0d, got %0d", e.error_code, got.error_code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  req_t in_req = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;
  logic out_valid;
  res_t out_res;

  arc_frame_replacer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  arc_scoreboard arc_sb = new();
  int gap_pct;
  logic [PAGE_W-1:0] page_pool[8];

  initial arc_sb.clear();

  // Results are checked as they are transferred.
  always @(posedge clk) begin
    if (rst_n && out_valid) arc_sb.check_result(out_res);
  end

  task automatic send_request(req_op_t op, int unsigned f, logic [PAGE_W-1:0] p, bit flag);
    req_t r;
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    r.req_type = op;
    r.frame_index = 4'(f);
    r.page_number = p;
    r.evictable_flag = flag;
    start <= 1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    arc_sb.note_request(r);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((arc_sb.pending_q.size() > 0 || busy) && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    arc_sb.capacity = 32'(v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Accesses are the largest share, on a small page set so ghost hits happen often.
  task automatic random_burst(int n);
    int unsigned k;
    logic [PAGE_W-1:0] p;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      p = ($urandom_range(9) == 0) ? PAGE_W'($urandom) : page_pool[$urandom_range(7)];
      if (k < 40) send_request(REQ_ACCESS, $urandom_range(15), p, 0);
      else if (k < 65) send_request(REQ_SETEV, $urandom_range(15), p, $urandom_range(3) != 0);
      else if (k < 75) send_request(REQ_REMOVE, $urandom_range(15), p, $urandom_range(1));
      else send_request(REQ_EVICT, $urandom_range(15), PAGE_W'($urandom), $urandom_range(1));
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps[6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9};
    gap_pct = 0;
    for (int i = 0; i < 8; i++) page_pool[i] = PAGE_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, errors, evict with none, ghost hits.
    send_request(REQ_EVICT, 0, '0, 0);
    send_request(REQ_SETEV, 15, '0, 1);
    send_request(REQ_REMOVE, 3, '0, 0);
    send_request(REQ_ACCESS, 0, '0, 0);
    send_request(REQ_ACCESS, 15, '1, 1);
    send_request(REQ_REMOVE, 0, '0, 0);
    send_request(REQ_SETEV, 0, '0, 1);
    send_request(REQ_SETEV, 15, '0, 1);
    send_request(REQ_SETEV, 15, '0, 1);
    send_request(REQ_ACCESS, 15, '1, 0);
    send_request(REQ_EVICT, 0, '0, 0);
    send_request(REQ_EVICT, 0, '0, 0);
    send_request(REQ_EVICT, 0, '0, 0);
    send_request(REQ_ACCESS, 5, '1, 0);
    send_request(REQ_ACCESS, 6, '0, 0);
    send_request(REQ_SETEV, 5, '0, 1);
    send_request(REQ_SETEV, 5, '0, 0);
    send_request(REQ_SETEV, 6, '0, 1);
    send_request(REQ_EVICT, 0, '0, 0);
    send_request(REQ_ACCESS, 7, '0, 0);
    send_request(REQ_REMOVE, 5, '0, 0);

    // Random phases across capacities and idle rates.
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      for (int j = 0; j < 4; j++) begin
        case (j)
          0: gap_pct = 0;
          1: gap_pct = 52;
          2: gap_pct = 0;
          default: gap_pct = 10;
        endcase
        random_burst(70);
      end
    end

    wait_idle();
    if (arc_sb.errors == 0 && arc_sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
design/afr_pkg.sv
design/afr_list.sv
design/arc_frame_replacer.sv
tb/tb_arc_frame_replacer.sv
